### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the escape parser.
// Needs nothing else; included by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/aecc_pkg.sv
// Package of the escape parser: result kinds, parser modes, constants and
// the colour map. Depends on nothing.
`default_nettype none

package aecc_pkg;

    localparam int MAX_PARAMS_DEF = 16;

    typedef enum logic [3:0] {
        K_PRINT    = 4'd0,
        K_ERASE    = 4'd1,
        K_UP       = 4'd2,
        K_DOWN     = 4'd3,
        K_CLEAR    = 4'd4,
        K_POSITION = 4'd5,
        K_HIDE     = 4'd6,
        K_SHOW     = 4'd7,
        K_ATTR     = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        M_TEXT      = 3'd0,
        M_ESC       = 3'd1,
        M_CSI_START = 3'd2,
        M_CSI       = 3'd3,
        M_OSC       = 3'd4,
        M_OSC_ESC   = 3'd5
    } mode_t;

    localparam logic [15:0] U_ESC   = 16'h001B;
    localparam logic [15:0] U_BEL   = 16'h0007;
    localparam logic [15:0] U_ST    = 16'h009C;
    localparam logic [15:0] U_LBRK  = 16'h005B;
    localparam logic [15:0] U_RBRK  = 16'h005D;
    localparam logic [15:0] U_QUEST = 16'h003F;
    localparam logic [15:0] U_SEMI  = 16'h003B;
    localparam logic [15:0] U_BSL   = 16'h005C;
    localparam logic [15:0] U_ZERO  = 16'h0030;
    localparam logic [15:0] U_NINE  = 16'h0039;
    localparam logic [15:0] F_K     = 16'h004B;
    localparam logic [15:0] F_A     = 16'h0041;
    localparam logic [15:0] F_B     = 16'h0042;
    localparam logic [15:0] F_J     = 16'h004A;
    localparam logic [15:0] F_F     = 16'h0066;
    localparam logic [15:0] F_L     = 16'h006C;
    localparam logic [15:0] F_H     = 16'h0068;
    localparam logic [15:0] F_M     = 16'h006D;
    localparam logic [15:0] P_CURSOR = 16'd25;

    localparam logic [15:0] A_FG_ALL  = 16'h0007;
    localparam logic [15:0] A_BG_ALL  = 16'h0070;
    localparam logic [15:0] A_FG_INT  = 16'h0008;
    localparam logic [15:0] A_REVERSE = 16'h4000;
    localparam logic [15:0] A_UNDER   = 16'h8000;

    // ANSI colour order to console colour bits (red and blue swap).
    function automatic logic [2:0] colour_map(input logic [2:0] c);
        logic [2:0] r;
        r = {c[0], c[1], c[2]};
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ansi_escape_to_console_commands.sv
// Top level of the ANSI escape parser: sequencer, parameter RAM and SGR unit.
// Depends on aecc_pkg, aecc_ram, aecc_sgr_step and assert_macros.svh.
//
// One UTF-16 code unit enters per input transaction (in_valid/in_ready);
// console commands leave as output transactions (out_valid/out_ready), none,
// one or two per input, with last set on the final one of the input.
// in_ready is high only while the sequencer is idle and no result waits.
// Text, digits, separators and OSC units are decoded in S_IDLE: a
// printed unit appears on the output in the cycle after acceptance. A CSI
// final character other than 'm' passes through S_RD0, S_RD1 and S_DEC to
// fetch its two leading parameters from the parameter RAM and decode them.
// An 'm' final walks the stored parameters through the SGR unit, each one
// through S_SGR_RD and S_SGR_AP and each 38 or 48 selector also through
// S_SGR_SL; the RAM has a single registered read port.
// A lone escape followed by text yields two results, delivered on two
// successive output transactions.
// When the receiver stalls, the result register holds and no new input
// transaction is taken until the last result of the item has been taken.
// Reset clears the parser to text mode, the attribute to 0x0007, the
// default attribute to 7 and passthrough to off. The parameter RAM is not
// cleared; entries are only used after being written. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while idle; unchecked.
`default_nettype none

module ansi_escape_to_console_commands
    import aecc_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] code_unit,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       result_kind,
    output logic [15:0]      char_out,
    output logic [15:0]      value_a,
    output logic [15:0]      value_b,
    output logic             last
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam int AW = $clog2(MAX_PARAMS);
    localparam int NW = $clog2(2 * MAX_PARAMS + 6);
    localparam logic [CW-1:0] MAXC = CW'(MAX_PARAMS);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD0    = 8'b0000_0010,
        S_RD1    = 8'b0000_0100,
        S_DEC    = 8'b0000_1000,
        S_SGR_RD = 8'b0001_0000,
        S_SGR_AP = 8'b0010_0000,
        S_SGR_SL = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic        pass_reg, pass_next;
    logic [15:0] dattr_reg, dattr_next;
    logic [15:0] tattr_reg, tattr_next;
    logic        priv_reg, priv_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0] accum_reg, accum_next;
    logic        digits_reg, digits_next;
    logic [15:0] final_reg, final_next;
    logic [15:0] p0_reg, p0_next;
    logic [15:0] wattr_reg, wattr_next;
    logic [NW-1:0] n_reg, n_next;
    logic        pend_reg, pend_next;
    logic [15:0] pchar_reg, pchar_next;

    logic        ov_reg, ov_next;
    logic [3:0]  kind_reg, kind_next;
    logic [15:0] ch_reg, ch_next;
    logic [15:0] a_reg, a_next;
    logic [15:0] b_reg, b_next;
    logic        last_reg, last_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   rdata;
    logic [15:0]   sgr_p, sgr_attr;
    logic          sgr_ext;
    logic [19:0]   acc_wide;
    logic [15:0]   p0e;
    logic [NW-1:0] cnt_eff, n_inc;

    aecc_ram #(.WIDTH(16), .DEPTH(MAX_PARAMS)) u_params (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (accum_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    aecc_sgr_step u_sgr (
        .attr         (wattr_reg),
        .p            (sgr_p),
        .default_attr (dattr_reg),
        .attr_new     (sgr_attr),
        .is_ext       (sgr_ext)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign result_kind = kind_reg;
    assign char_out    = ch_reg;
    assign value_a     = a_reg;
    assign value_b     = b_reg;
    assign last        = last_reg;

    assign waddr    = count_reg[AW-1:0];
    assign sgr_p    = (count_reg == '0) ? 16'd0 : rdata;
    assign cnt_eff  = (count_reg == '0) ? NW'(1) : NW'(count_reg);
    assign n_inc    = n_reg + NW'(1);
    assign p0e      = (count_reg == '0) ? 16'd0 : p0_reg;
    assign acc_wide = {1'b0, accum_reg, 3'd0} + {3'd0, accum_reg, 1'b0}
                    + {16'd0, code_unit[3:0]};

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        pass_next   = pass_reg;
        dattr_next  = dattr_reg;
        tattr_next  = tattr_reg;
        priv_next   = priv_reg;
        count_next  = count_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        final_next  = final_reg;
        p0_next     = p0_reg;
        wattr_next  = wattr_reg;
        n_next      = n_reg;
        pend_next   = pend_reg;
        pchar_next  = pchar_reg;
        ov_next     = ov_reg;
        kind_next   = kind_reg;
        ch_next     = ch_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        last_next   = last_reg;
        we          = 1'b0;
        raddr       = n_reg[AW-1:0];

        if (cfg_we)
        begin
            if (cfg_index == 1'b0)
            begin
                pass_next = cfg_data[0];
            end
            else
            begin
                dattr_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // Default: a single printed unit.
                    kind_next = K_PRINT;
                    ch_next   = code_unit;
                    a_next    = '0;
                    b_next    = '0;
                    last_next = 1'b1;
                    if (pass_reg)
                    begin
                        ov_next    = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        case (mode_reg)
                            M_ESC:
                            begin
                                if (code_unit == U_LBRK)
                                begin
                                    priv_next   = 1'b0;
                                    count_next  = '0;
                                    accum_next  = '0;
                                    digits_next = 1'b0;
                                    mode_next   = M_CSI_START;
                                end
                                else if (code_unit == U_RBRK)
                                begin
                                    mode_next = M_OSC;
                                end
                                else
                                begin
                                    // The escape is printed literally first.
                                    ch_next    = U_ESC;
                                    ov_next    = 1'b1;
                                    state_next = S_OUT;
                                    if (code_unit == U_ESC)
                                    begin
                                        mode_next = M_ESC;
                                    end
                                    else
                                    begin
                                        mode_next  = M_TEXT;
                                        last_next  = 1'b0;
                                        pend_next  = 1'b1;
                                        pchar_next = code_unit;
                                    end
                                end
                            end
                            M_CSI_START, M_CSI:
                            begin
                                mode_next = M_CSI;
                                if (mode_reg == M_CSI_START && code_unit == U_QUEST)
                                begin
                                    priv_next = 1'b1;
                                end
                                else if (count_reg < MAXC && code_unit >= U_ZERO
                                         && code_unit <= U_NINE)
                                begin
                                    accum_next  = (acc_wide > 20'hFFFF) ? 16'hFFFF
                                                                        : acc_wide[15:0];
                                    digits_next = 1'b1;
                                end
                                else if (count_reg < MAXC && code_unit == U_SEMI
                                         && digits_reg)
                                begin
                                    we          = 1'b1;
                                    count_next  = count_reg + CW'(1);
                                    accum_next  = '0;
                                    digits_next = 1'b0;
                                end
                                else
                                begin
                                    if (count_reg < MAXC && digits_reg)
                                    begin
                                        we         = 1'b1;
                                        count_next = count_reg + CW'(1);
                                    end
                                    accum_next  = '0;
                                    digits_next = 1'b0;
                                    final_next  = code_unit;
                                    mode_next   = M_TEXT;
                                    n_next      = '0;
                                    wattr_next  = tattr_reg;
                                    state_next  = (code_unit == F_M) ? S_SGR_RD : S_RD0;
                                end
                            end
                            M_OSC:
                            begin
                                if (code_unit == U_BEL || code_unit == U_ST)
                                begin
                                    mode_next = M_TEXT;
                                end
                                else if (code_unit == U_ESC)
                                begin
                                    mode_next = M_OSC_ESC;
                                end
                            end
                            M_OSC_ESC:
                            begin
                                if (code_unit == U_BSL || code_unit == U_BEL
                                    || code_unit == U_ST)
                                begin
                                    mode_next = M_TEXT;
                                end
                                else if (code_unit != U_ESC)
                                begin
                                    mode_next = M_OSC;
                                end
                            end
                            default:
                            begin
                                mode_next = M_TEXT;
                                if (code_unit == U_ESC)
                                begin
                                    mode_next = M_ESC;
                                end
                                else
                                begin
                                    ov_next    = 1'b1;
                                    state_next = S_OUT;
                                end
                            end
                        endcase
                    end
                end
            end
            S_RD0:
            begin
                raddr      = '0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                raddr      = AW'(1);
                p0_next    = rdata;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                kind_next = K_PRINT;
                ch_next   = '0;
                a_next    = '0;
                b_next    = '0;
                last_next = 1'b1;
                case (final_reg)
                    F_K:
                    begin
                        ov_next   = 1'b1;
                        kind_next = K_ERASE;
                        a_next    = (p0e == 16'd1 || p0e == 16'd2) ? p0e : 16'd0;
                    end
                    F_A, F_B:
                    begin
                        ov_next   = 1'b1;
                        kind_next = (final_reg == F_A) ? K_UP : K_DOWN;
                        a_next    = (count_reg == '0) ? 16'd1 : p0_reg;
                    end
                    F_J:
                    begin
                        ov_next   = (count_reg != '0) && (p0_reg == 16'd2);
                        kind_next = K_CLEAR;
                    end
                    F_F:
                    begin
                        ov_next   = (count_reg == CW'(2));
                        kind_next = K_POSITION;
                        a_next    = p0_reg;
                        b_next    = rdata;
                    end
                    F_L, F_H:
                    begin
                        ov_next   = priv_reg && (count_reg != '0) && (p0_reg == P_CURSOR);
                        kind_next = (final_reg == F_L) ? K_HIDE : K_SHOW;
                    end
                    default:
                    begin
                        ov_next = 1'b0;
                    end
                endcase
                priv_next  = 1'b0;
                count_next = '0;
                state_next = ov_next ? S_OUT : S_IDLE;
            end
            S_SGR_RD:
            begin
                state_next = S_SGR_AP;
            end
            S_SGR_AP:
            begin
                wattr_next = sgr_attr;
                raddr      = n_inc[AW-1:0];
                if (sgr_ext && n_inc < cnt_eff)
                begin
                    state_next = S_SGR_SL;
                end
                else
                begin
                    n_next = n_inc;
                    if (n_inc < cnt_eff)
                    begin
                        state_next = S_SGR_RD;
                    end
                    else
                    begin
                        // Walk done: report only a changed attribute.
                        priv_next  = 1'b0;
                        count_next = '0;
                        kind_next  = K_ATTR;
                        ch_next    = '0;
                        a_next     = sgr_attr;
                        b_next     = '0;
                        last_next  = 1'b1;
                        tattr_next = sgr_attr;
                        ov_next    = (sgr_attr != tattr_reg);
                        state_next = ov_next ? S_OUT : S_IDLE;
                    end
                end
            end
            S_SGR_SL:
            begin
                // Skip the selector and the extended colour's arguments.
                if (rdata == 16'd5)
                begin
                    n_next = n_reg + NW'(3);
                end
                else if (rdata == 16'd2)
                begin
                    n_next = n_reg + NW'(5);
                end
                else
                begin
                    n_next = n_reg + cnt_eff + NW'(1);
                end
                raddr = n_next[AW-1:0];
                if (n_next < cnt_eff)
                begin
                    state_next = S_SGR_RD;
                end
                else
                begin
                    priv_next  = 1'b0;
                    count_next = '0;
                    kind_next  = K_ATTR;
                    ch_next    = '0;
                    a_next     = wattr_reg;
                    b_next     = '0;
                    last_next  = 1'b1;
                    tattr_next = wattr_reg;
                    ov_next    = (wattr_reg != tattr_reg);
                    state_next = ov_next ? S_OUT : S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        kind_next = K_PRINT;
                        ch_next   = pchar_reg;
                        a_next    = '0;
                        b_next    = '0;
                        last_next = 1'b1;
                    end
                    else
                    begin
                        ov_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= M_TEXT;
            pass_reg   <= 1'b0;
            dattr_reg  <= 16'h0007;
            tattr_reg  <= 16'h0007;
            priv_reg   <= 1'b0;
            count_reg  <= '0;
            accum_reg  <= '0;
            digits_reg <= 1'b0;
            n_reg      <= '0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            pass_reg   <= pass_next;
            dattr_reg  <= dattr_next;
            tattr_reg  <= tattr_next;
            priv_reg   <= priv_next;
            count_reg  <= count_next;
            accum_reg  <= accum_next;
            digits_reg <= digits_next;
            n_reg      <= n_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        final_reg <= final_next;
        p0_reg    <= p0_next;
        wattr_reg <= wattr_next;
        pchar_reg <= pchar_next;
        kind_reg  <= kind_next;
        ch_reg    <= ch_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        last_reg  <= last_next;
    end

    `ASSERT_IMPL(a_out_only_in_out, clk, rst_n, ov_reg, state_reg == S_OUT,
                 "result shown outside the output state")
    `ASSERT_IMPL(a_pend_has_out, clk, rst_n, pend_reg, ov_reg && !last_reg,
                 "pending print without a first result")
    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= MAXC,
                 "parameter count beyond its limit")
    `ASSERT_NEXT(a_second_follows, clk, rst_n, ov_reg && out_ready && !last_reg,
                 ov_reg && last_reg, "second result of an item lost")

endmodule

`default_nettype wire

### hw/rtl/aecc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module aecc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/aecc_sgr_step.sv
// Applies one SGR parameter to a text attribute word.
// Depends on aecc_pkg.
`default_nettype none

module aecc_sgr_step
    import aecc_pkg::*;
(
    input  wire logic [15:0] attr,
    input  wire logic [15:0] p,
    input  wire logic [15:0] default_attr,
    output logic      [15:0] attr_new,
    output logic             is_ext
);

    logic [15:0] off;
    logic [15:0] off_bg;

    always_comb
    begin
        off      = p - 16'd30;
        off_bg   = p - 16'd40;
        attr_new = attr;
        is_ext   = (p == 16'd38) || (p == 16'd48);
        if (p == 16'd0)
        begin
            attr_new = default_attr;
        end
        else if (p == 16'd1)
        begin
            attr_new = attr | A_FG_INT;
        end
        else if (p == 16'd22)
        begin
            attr_new = attr & ~A_FG_INT;
        end
        else if (p == 16'd4)
        begin
            attr_new = attr | A_UNDER;
        end
        else if (p == 16'd24)
        begin
            attr_new = attr & ~A_UNDER;
        end
        else if (p == 16'd7)
        begin
            attr_new = attr | A_REVERSE;
        end
        else if (p == 16'd27)
        begin
            attr_new = attr & ~A_REVERSE;
        end
        else if (p >= 16'd30 && p <= 16'd37)
        begin
            attr_new = (attr & ~A_FG_ALL) | {13'd0, colour_map(off[2:0])};
        end
        else if (p == 16'd39)
        begin
            attr_new = (attr & ~A_FG_ALL) | (default_attr & A_FG_ALL);
        end
        else if (p >= 16'd40 && p <= 16'd47)
        begin
            attr_new = (attr & ~A_BG_ALL) | {9'd0, colour_map(off_bg[2:0]), 4'd0};
        end
        else if (p == 16'd49)
        begin
            attr_new = (attr & ~A_BG_ALL) | (default_attr & A_BG_ALL);
        end
    end

endmodule

`default_nettype wire

### verif/aecc_checker.sv
// Checker for the ANSI escape parser: watches both channels and the
// configuration port, predicts every command and compares it. Uses aecc_pkg.
`default_nettype none

module aecc_checker
    import aecc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [15:0] code_unit,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [3:0]  result_kind,
    input  wire logic [15:0] char_out,
    input  wire logic [15:0] value_a,
    input  wire logic [15:0] value_b,
    input  wire logic        last,
    output int               fail_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] ch;
        logic [15:0] a;
        logic [15:0] b;
        logic        fin;
    } console_cmd_t;

    localparam logic [2:0] ANSI_TO_CONSOLE [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                                  3'd1, 3'd5, 3'd3, 3'd7};

    console_cmd_t expected_cmds[$];

    logic        pass_all;
    logic [15:0] dflt_attr;
    mode_t       mode;
    logic        priv;
    logic [15:0] params [MAX_PARAMS_DEF];
    int unsigned nparams;
    int unsigned accum;
    logic        have_digits;
    logic [15:0] attr;

    console_cmd_t new_cmds[2];
    int           n_new;

    task automatic add_cmd(input logic [3:0] kind, input logic [15:0] ch,
                           input logic [15:0] a, input logic [15:0] b);
        new_cmds[n_new] = '{kind, ch, a, b, 1'b0};
        n_new++;
    endtask

    task automatic store_param();
        if (nparams < MAX_PARAMS_DEF)
        begin
            params[nparams] = accum[15:0];
            nparams++;
        end
        accum = 0;
        have_digits = 0;
    endtask

    function automatic logic [15:0] sgr_result(input logic [15:0] cur);
        logic [15:0] vals [MAX_PARAMS_DEF];
        int unsigned cnt;
        int unsigned n;
        int unsigned p;
        int unsigned sel;
        vals = params;
        cnt = nparams;
        if (cnt == 0)
        begin
            vals[0] = 0;
            cnt = 1;
        end
        n = 0;
        while (n < cnt && n < MAX_PARAMS_DEF)
        begin
            p = vals[n];
            if (p == 0) cur = dflt_attr;
            else if (p == 1) cur |= A_FG_INT;
            else if (p == 22) cur &= ~A_FG_INT;
            else if (p == 4) cur |= A_UNDER;
            else if (p == 24) cur &= ~A_UNDER;
            else if (p == 7) cur |= A_REVERSE;
            else if (p == 27) cur &= ~A_REVERSE;
            else if (p >= 30 && p <= 37)
                cur = (cur & ~A_FG_ALL) | 16'(ANSI_TO_CONSOLE[p - 30]);
            else if (p == 39)
                cur = (cur & ~A_FG_ALL) | (dflt_attr & A_FG_ALL);
            else if (p >= 40 && p <= 47)
                cur = (cur & ~A_BG_ALL) | (16'(ANSI_TO_CONSOLE[p - 40]) << 4);
            else if (p == 49)
                cur = (cur & ~A_BG_ALL) | (dflt_attr & A_BG_ALL);
            else if ((p == 38 || p == 48) && n + 1 < cnt)
            begin
                sel = vals[n + 1];
                n += (sel == 5) ? 2 : (sel == 2) ? 4 : cnt;
            end
            n++;
        end
        return cur;
    endfunction

    task automatic finish_sequence(input logic [15:0] c);
        logic [15:0] p0;
        logic [15:0] na;
        p0 = (nparams != 0) ? params[0] : 16'd0;
        case (c)
            F_K: add_cmd(K_ERASE, 0, (p0 == 1 || p0 == 2) ? p0 : 16'd0, 0);
            F_A: add_cmd(K_UP, 0, (nparams != 0) ? p0 : 16'd1, 0);
            F_B: add_cmd(K_DOWN, 0, (nparams != 0) ? p0 : 16'd1, 0);
            F_J: if (nparams != 0 && p0 == 2) add_cmd(K_CLEAR, 0, 0, 0);
            F_F: if (nparams == 2) add_cmd(K_POSITION, 0, params[0], params[1]);
            F_L: if (priv && nparams != 0 && p0 == P_CURSOR) add_cmd(K_HIDE, 0, 0, 0);
            F_H: if (priv && nparams != 0 && p0 == P_CURSOR) add_cmd(K_SHOW, 0, 0, 0);
            F_M:
            begin
                na = sgr_result(attr);
                if (na != attr)
                begin
                    attr = na;
                    add_cmd(K_ATTR, 0, na, 0);
                end
            end
            default: ;
        endcase
        priv = 0;
        nparams = 0;
        accum = 0;
        have_digits = 0;
        mode = M_TEXT;
    endtask

    task automatic csi_char(input logic [15:0] c);
        int unsigned v;
        if (nparams >= MAX_PARAMS_DEF)
            finish_sequence(c);
        else if (c >= U_ZERO && c <= U_NINE)
        begin
            v = accum * 10 + (c - U_ZERO);
            accum = (v > 65535) ? 65535 : v;
            have_digits = 1;
        end
        else if (c == U_SEMI && have_digits)
            store_param();
        else
        begin
            if (have_digits)
                store_param();
            finish_sequence(c);
        end
    endtask

    task automatic plain_char(input logic [15:0] c);
        if (c == U_ESC)
            mode = M_ESC;
        else
            add_cmd(K_PRINT, c, 0, 0);
    endtask

    task automatic predict_unit(input logic [15:0] c);
        n_new = 0;
        if (pass_all)
            add_cmd(K_PRINT, c, 0, 0);
        else
        begin
            case (mode)
                M_ESC:
                    if (c == U_LBRK)
                    begin
                        priv = 0;
                        nparams = 0;
                        accum = 0;
                        have_digits = 0;
                        mode = M_CSI_START;
                    end
                    else if (c == U_RBRK)
                        mode = M_OSC;
                    else
                    begin
                        add_cmd(K_PRINT, U_ESC, 0, 0);
                        mode = M_TEXT;
                        plain_char(c);
                    end
                M_CSI_START:
                begin
                    mode = M_CSI;
                    if (c == U_QUEST)
                        priv = 1;
                    else
                        csi_char(c);
                end
                M_CSI: csi_char(c);
                M_OSC:
                    if (c == U_BEL || c == U_ST)
                        mode = M_TEXT;
                    else if (c == U_ESC)
                        mode = M_OSC_ESC;
                M_OSC_ESC:
                    if (c == U_BSL || c == U_BEL || c == U_ST)
                        mode = M_TEXT;
                    else if (c != U_ESC)
                        mode = M_OSC;
                default:
                begin
                    mode = M_TEXT;
                    plain_char(c);
                end
            endcase
        end
        for (int i = 0; i < n_new; i++)
        begin
            new_cmds[i].fin = (i == n_new - 1);
            expected_cmds.push_back(new_cmds[i]);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pass_all = 0;
        dflt_attr = 16'd7;
        mode = M_TEXT;
        priv = 0;
        nparams = 0;
        accum = 0;
        have_digits = 0;
        attr = 16'd7;
    end

    always @(posedge clk)
    begin
        console_cmd_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_cmds.size() == 0)
                    report_mismatch("command with none expected");
                else
                begin
                    e = expected_cmds.pop_front();
                    if (result_kind !== e.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d", result_kind, e.kind));
                    if (char_out !== e.ch)
                        report_mismatch($sformatf("char %h, expected %h", char_out, e.ch));
                    if (value_a !== e.a)
                        report_mismatch($sformatf("value_a %h, expected %h", value_a, e.a));
                    if (value_b !== e.b)
                        report_mismatch($sformatf("value_b %h, expected %h", value_b, e.b));
                    if (last !== e.fin)
                        report_mismatch($sformatf("last %b, expected %b", last, e.fin));
                end
            end
            if (in_valid && in_ready)
                predict_unit(code_unit);
            if (cfg_we)
            begin
                if (cfg_index == 1'b0)
                    pass_all = cfg_data[0];
                else
                    dflt_attr = cfg_data;
            end
        end
        outstanding <= expected_cmds.size();
    end

endmodule

`default_nettype wire

### verif/ansi_escape_to_console_commands_tb.sv
// Top of the escape parser testbench: clock, reset, stimulus and verdict.
// Depends on aecc_pkg, aecc_checker and the parser RTL.
`default_nettype none

module ansi_escape_to_console_commands_tb;
    import aecc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] code_unit;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  result_kind;
    logic [15:0] char_out;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic        last;
    int          fail_count;
    int          outstanding;

    // Handshake seen at the last rising edge, read by the driver at the falling edge.
    logic        unit_taken;
    int          idle_pct;
    int          stall_pct;
    bit          hold_req;
    int          units_sent;
    int          quiet_cycles;

    ansi_escape_to_console_commands i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .code_unit(code_unit),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .char_out(char_out),
        .value_a(value_a), .value_b(value_b), .last(last)
    );

    aecc_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .code_unit(code_unit),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .char_out(char_out),
        .value_a(value_a), .value_b(value_b), .last(last),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // A 12 ns clock, high and low for half a period each.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        unit_taken <= in_valid && in_ready;

    // The watchdog counts cycles in which neither channel completes a
    // transaction; a stuck block or a lost handshake ends the run here.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL ansi_escape_to_console_commands");
            $finish;
        end
    end

    // The receiver stalls at random. When a hold-off is requested it keeps
    // ready low for a long, self-counted stretch so that the parser backs up
    // and stops taking input while the sender keeps offering transactions.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one code unit and waits for its transaction. Called at a falling
    // edge; valid is only lowered when the sender decides to go idle, so it
    // never drops between two back-to-back transactions.
    task automatic send_unit(input logic [15:0] u);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        code_unit <= u;
        do @(negedge clk); while (!unit_taken);
        units_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_unit(16'(s[i]));
    endtask

    // Registers may only change with nothing in flight. Units that produce no
    // command can still be working inside the parser, so allow the longest
    // SGR walk to finish before writing.
    task automatic write_config(input logic pass, input logic [15:0] dflt);
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 1'b0;
        cfg_data <= {15'd0, pass};
        @(negedge clk);
        cfg_index <= 1'b1;
        cfg_data <= dflt;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] sgr_value();
        int pick;
        pick = $urandom_range(11);
        case (pick)
            0: return 16'd0;
            1: return 16'd1;
            2: return ($urandom_range(1)) ? 16'd22 : 16'd24;
            3: return ($urandom_range(1)) ? 16'd4 : 16'd27;
            4: return 16'd7;
            5: return 16'($urandom_range(30, 37));
            6: return 16'($urandom_range(40, 47));
            7: return ($urandom_range(1)) ? 16'd39 : 16'd49;
            8: return ($urandom_range(1)) ? 16'd38 : 16'd48;
            9: return ($urandom_range(1)) ? 16'd5 : 16'd2;
            10: return 16'd25;
            default: return 16'($urandom_range(99));
        endcase
    endfunction

    // One CSI sequence with random parameters and a final character drawn
    // mostly from the recognised set.
    task automatic send_csi();
        string finals;
        int    np;
        int    v;
        finals = "KABJfhlmmmf";
        send_unit(U_ESC);
        send_unit(U_LBRK);
        if ($urandom_range(2) == 0)
            send_unit(U_QUEST);
        np = ($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
        for (int i = 0; i < np; i++)
        begin
            if (i > 0)
                send_unit(U_SEMI);
            if ($urandom_range(19) == 0)
                v = $urandom_range(65530, 200000);
            else
                v = sgr_value();
            if ($urandom_range(24) != 0)
                send_text($sformatf("%0d", v));
        end
        case ($urandom_range(9))
            0: send_unit(16'($urandom));
            1: send_unit(U_ESC);
            default: send_unit(16'(finals[$urandom_range(finals.len() - 1)]));
        endcase
    endtask

    // An OSC string with random body, stray escapes and one of its terminators.
    task automatic send_osc();
        int n;
        send_unit(U_ESC);
        send_unit(U_RBRK);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(5) == 0)
                send_unit(U_ESC);
            send_unit(16'($urandom_range(32, 126)));
        end
        case ($urandom_range(2))
            0: send_unit(U_BEL);
            1: send_unit(U_ST);
            default:
            begin
                send_unit(U_ESC);
                send_unit(U_BSL);
            end
        endcase
    endtask

    task automatic send_random_sequence();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            send_unit(($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(32, 126)));
        else if (r < 75)
            send_csi();
        else if (r < 85)
            send_osc();
        else if (r < 95)
        begin
            send_unit(U_ESC);
            send_unit(($urandom_range(3) == 0) ? U_ESC : 16'($urandom));
        end
        else
            send_unit(16'($urandom_range(0, 127)));
    endtask

    task automatic run_phase(input int idle, input int stall, input int units);
        int stop_at;
        idle_pct = idle;
        stall_pct = stall;
        stop_at = units_sent + units;
        while (units_sent < stop_at)
            send_random_sequence();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 16'd0;
        in_valid = 1'b0;
        code_unit = 16'd0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        units_sent = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset settings: each command but down and show, saturation,
        // private cursor control, a lone escape, an OSC and the extreme code units.
        send_unit(16'h0000);
        send_unit(16'hFFFF);
        send_text("\033[2K\033[A\033[2J\033[?25l\033[3;99999f\033[1;31;44m");
        send_text("\033[38;5;9m\033[0m\033x\033]t\007");

        write_config(1'b0, 16'hFFFF);
        run_phase(0, 0, 130);

        write_config(1'b1, 16'h0000);
        run_phase(66, 0, 100);

        write_config(1'b0, 16'h0000);
        // The long hold-off lands while the sender is still busy.
        hold_req = 1;
        run_phase(0, 66, 130);

        write_config(1'b0, 16'($urandom));
        run_phase(22, 22, 130);

        write_config(1'b0, 16'h0007);
        run_phase(0, 0, 130);

        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("PASS ansi_escape_to_console_commands");
        else
            $display("FAIL ansi_escape_to_console_commands");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/aecc_pkg.sv
hw/rtl/aecc_ram.sv
hw/rtl/aecc_sgr_step.sv
hw/rtl/ansi_escape_to_console_commands.sv
verif/aecc_checker.sv
verif/ansi_escape_to_console_commands_tb.sv
